>>> sv/mlps_pkg.sv
package mlps_pkg;

   localparam int NumLevelsDef  = 6;
   localparam int LevelDepthDef = 16;
   localparam int IdBitsDef     = 16;

   localparam logic [1:0] StReady   = 2'd0;
   localparam logic [1:0] StRunning = 2'd1;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_REM_RUN = 3'd2,
      OP_SCHED   = 3'd3,
      OP_SET     = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_FULL     = 3'd1,
      STS_NOTFOUND = 3'd2,
      STS_NOREADY  = 3'd3,
      STS_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] task_id;
      logic [2:0]  level;
      logic [1:0]  state_value;
   } req_type;

   typedef struct packed {
      logic [15:0] result_id;
      logic [2:0]  result_level;
      logic [2:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_WAIT,
      S_COMPACT,
      S_COMPACT_WAIT,
      S_APPEND,
      S_LEVEL_NEXT,
      S_DONE
   } state_type;

endpackage

>>> sv/multilevel_priority_scheduler_unit.sv
// Operations are carried out by a sequencer that walks one shared entry memory
// with one write port and one read port, reading one entry at a time.
// Insert appends at the tail of its level. Remove / schedule scan a level and then
// compact it, moving the entries behind the hit. Set-state walks every level,
// remove-running scans every level and compacts each one that holds a running entry.
// One operation at a time; the result sits in an output register.
// Synchronous active-high reset clears counts and control; entries are not cleared.
module multilevel_priority_scheduler_unit #(
   parameter int NUM_LEVELS  = mlps_pkg::NumLevelsDef,
   parameter int LEVEL_DEPTH = mlps_pkg::LevelDepthDef,
   parameter int ID_BITS     = mlps_pkg::IdBitsDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mlps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mlps_pkg::rsp_type rsp_data
);

   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PW = $clog2(LEVEL_DEPTH);
   localparam int CW = $clog2(LEVEL_DEPTH + 1);
   localparam int AW = LW + PW;
   localparam int EW = ID_BITS + 2;

   // entry memory: {id, state}, address {level, pos}
   logic [EW-1:0] mem [NUM_LEVELS * (2 ** PW)];
   logic [EW-1:0] rd_ff;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [EW-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   logic [CW-1:0] cnt_ff [NUM_LEVELS];

   mlps_pkg::state_type state_ff, state_in;
   mlps_pkg::req_type   req_ff, req_in;
   logic [LW-1:0] lv_ff, lv_in;
   logic [CW-1:0] k_ff, k_in;       // read position
   logic [CW-1:0] w_ff, w_in;       // write position during compaction
   logic          hit_ff, hit_in;   // something found in current op
   logic          any_ff, any_in;
   logic          miss_ff, miss_in;
   logic [ID_BITS-1:0] tid_ff, tid_in; // target id
   logic          cnt_we;
   logic [CW-1:0] cnt_wv;
   logic          rsp_valid_ff, rsp_valid_in;
   mlps_pkg::rsp_type rsp_ff, rsp_in;

   logic [ID_BITS-1:0] rid;
   logic [1:0]         rst;
   logic [ID_BITS-1:0] req_id;
   logic               lv_ok;
   logic [CW-1:0]      cur_cnt;

   assign rid     = rd_ff[EW-1:2];
   assign rst     = rd_ff[1:0];
   assign req_id  = ID_BITS'(req_ff.task_id);
   assign lv_ok   = 32'(req_ff.level) < NUM_LEVELS;
   assign cur_cnt = cnt_ff[lv_ff];

   function automatic logic [AW-1:0] addr(logic [LW-1:0] l, logic [CW-1:0] p);
      return {l, PW'(p)};
   endfunction

   // hold level counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) cnt_ff[i] <= '0;
      end else if (cnt_we) begin
         cnt_ff[lv_ff] <= cnt_wv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlps_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      lv_ff   <= lv_in;
      k_ff    <= k_in;
      w_ff    <= w_in;
      hit_ff  <= hit_in;
      any_ff  <= any_in;
      miss_ff <= miss_in;
      tid_ff  <= tid_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == mlps_pkg::S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      req_in = req_ff; lv_in = lv_ff; k_in = k_ff; w_in = w_ff;
      hit_in = hit_ff; any_in = any_ff; miss_in = miss_ff; tid_in = tid_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      we = 1'b0; waddr = addr(lv_ff, w_ff); wdata = rd_ff;
      raddr = addr(lv_ff, k_ff);
      cnt_we = 1'b0; cnt_wv = cur_cnt;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         mlps_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               k_in = '0; w_in = '0; hit_in = 1'b0; any_in = 1'b0; miss_in = 1'b0;
               lv_in = '0;
               tid_in = ID_BITS'(req_data.task_id);
               rsp_in = '0;
               unique case (req_data.op)
                  mlps_pkg::OP_INSERT, mlps_pkg::OP_REMOVE: begin
                     lv_in = LW'(req_data.level);
                     state_in = (req_data.op == mlps_pkg::OP_INSERT) ?
                                mlps_pkg::S_APPEND : mlps_pkg::S_SCAN;
                  end
                  mlps_pkg::OP_REM_RUN, mlps_pkg::OP_SCHED, mlps_pkg::OP_SET:
                     state_in = mlps_pkg::S_SCAN;
                  default: state_in = mlps_pkg::S_DONE;
               endcase
            end
         end

         // insert, or schedule re-append of rid at tail
         mlps_pkg::S_APPEND: begin
            if (req_ff.op == mlps_pkg::OP_INSERT) begin
               if (!lv_ok || 32'(cur_cnt) >= LEVEL_DEPTH) begin
                  rsp_in.status = mlps_pkg::STS_FULL;
               end else begin
                  we = 1'b1; waddr = addr(lv_ff, cur_cnt);
                  wdata = {req_id, req_ff.state_value};
                  cnt_we = 1'b1; cnt_wv = cur_cnt + 1'b1;
               end
            end else begin
               we = 1'b1; waddr = addr(lv_ff, cur_cnt - 1'b1);
               wdata = {tid_ff, mlps_pkg::StRunning};
               rsp_in.result_id = 16'(tid_ff);
               rsp_in.result_level = 3'(lv_ff);
            end
            state_in = mlps_pkg::S_DONE;
         end

         // scan phase: issue read of entry k
         mlps_pkg::S_SCAN: begin
            if (req_ff.op == mlps_pkg::OP_REMOVE && !lv_ok) begin
               rsp_in.status = mlps_pkg::STS_NOTFOUND;
               state_in = mlps_pkg::S_DONE;
            end else if (k_ff < cur_cnt) begin
               state_in = mlps_pkg::S_SCAN_WAIT;
            end else begin
               state_in = mlps_pkg::S_LEVEL_NEXT;
            end
         end

         mlps_pkg::S_SCAN_WAIT: begin
            k_in = k_ff + 1'b1;
            state_in = mlps_pkg::S_SCAN;
            unique case (req_ff.op)
               mlps_pkg::OP_REMOVE: begin
                  if (rid == tid_ff) begin
                     hit_in = 1'b1; w_in = k_ff; state_in = mlps_pkg::S_COMPACT;
                  end
               end
               mlps_pkg::OP_REM_RUN: begin
                  if (rst == mlps_pkg::StRunning) begin
                     hit_in = 1'b1; tid_in = rid;
                  end
               end
               mlps_pkg::OP_SCHED: begin
                  if (rst == mlps_pkg::StReady) begin
                     hit_in = 1'b1; tid_in = rid; w_in = k_ff;
                     state_in = mlps_pkg::S_COMPACT;
                  end
               end
               default: begin
                  if (rid == tid_ff && rst == mlps_pkg::StRunning) begin
                     hit_in = 1'b1;
                     we = 1'b1; waddr = addr(lv_ff, k_ff);
                     wdata = {rid, req_ff.state_value};
                  end
               end
            endcase
         end

         // compaction: k reads, w writes; drop matching ids (or only first for schedule)
         mlps_pkg::S_COMPACT: begin
            if (k_ff < cur_cnt) begin
               state_in = mlps_pkg::S_COMPACT_WAIT;
            end else begin
               cnt_we = 1'b1; cnt_wv = w_ff;
               if (req_ff.op == mlps_pkg::OP_SCHED) begin
                  cnt_wv = w_ff + 1'b1;
                  state_in = mlps_pkg::S_APPEND;
               end else if (req_ff.op == mlps_pkg::OP_REM_RUN) begin
                  state_in = mlps_pkg::S_LEVEL_NEXT;
               end else begin
                  state_in = mlps_pkg::S_DONE;
               end
            end
         end

         mlps_pkg::S_COMPACT_WAIT: begin
            k_in = k_ff + 1'b1;
            state_in = mlps_pkg::S_COMPACT;
            if (req_ff.op == mlps_pkg::OP_SCHED || rid != tid_ff) begin
               we = 1'b1; waddr = addr(lv_ff, w_ff);
               w_in = w_ff + 1'b1;
            end
         end

         // end of a level scan
         mlps_pkg::S_LEVEL_NEXT: begin
            k_in = '0;
            unique case (req_ff.op)
               mlps_pkg::OP_REMOVE: begin
                  rsp_in.status = mlps_pkg::STS_NOTFOUND;
                  state_in = mlps_pkg::S_DONE;
               end
               mlps_pkg::OP_SCHED: begin
                  if (cur_cnt != '0) begin
                     rsp_in.status = mlps_pkg::STS_NOREADY;
                     rsp_in.result_level = 3'(lv_ff);
                     state_in = mlps_pkg::S_DONE;
                  end else if (32'(lv_ff) == NUM_LEVELS - 1) begin
                     rsp_in.status = mlps_pkg::STS_EMPTY;
                     state_in = mlps_pkg::S_DONE;
                  end else begin
                     lv_in = lv_ff + 1'b1; state_in = mlps_pkg::S_SCAN;
                  end
               end
               mlps_pkg::OP_REM_RUN: begin
                  if (hit_ff) begin
                     // running entry found: compact this level from the start
                     any_in = 1'b1; hit_in = 1'b0; w_in = '0;
                     state_in = mlps_pkg::S_COMPACT;
                  end else begin
                     // a plain scan leaves k at the count, a compaction leaves it above
                     if (k_ff == cur_cnt && cur_cnt != '0) begin
                        any_in = 1'b1; miss_in = 1'b1;
                     end
                     if (32'(lv_ff) == NUM_LEVELS - 1) begin
                        if (!any_in) rsp_in.status = mlps_pkg::STS_EMPTY;
                        else if (miss_in) rsp_in.status = mlps_pkg::STS_NOTFOUND;
                        else rsp_in.status = mlps_pkg::STS_OK;
                        state_in = mlps_pkg::S_DONE;
                     end else begin
                        lv_in = lv_ff + 1'b1; state_in = mlps_pkg::S_SCAN;
                     end
                  end
               end
               default: begin
                  if (32'(lv_ff) == NUM_LEVELS - 1) begin
                     rsp_in.status = hit_ff ? mlps_pkg::STS_OK : mlps_pkg::STS_NOTFOUND;
                     state_in = mlps_pkg::S_DONE;
                  end else begin
                     lv_in = lv_ff + 1'b1; state_in = mlps_pkg::S_SCAN;
                  end
               end
            endcase
         end

         mlps_pkg::S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = mlps_pkg::S_IDLE;
         end

         default: state_in = mlps_pkg::S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_rdy_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == mlps_pkg::S_IDLE)
      else $error("ready outside idle");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == mlps_pkg::S_DONE |=> rsp_valid)
      else $error("done without response");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("accept while response pending");
`endif

endmodule

>>> tb/sv/multilevel_priority_scheduler_unit_tb.sv
`timescale 1ns / 100ps

module multilevel_priority_scheduler_unit_tb;

   localparam int Levels = mlps_pkg::NumLevelsDef;
   localparam int Depth  = mlps_pkg::LevelDepthDef;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   mlps_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   mlps_pkg::rsp_type rsp_data;

   multilevel_priority_scheduler_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Shadow copy of the task levels
   logic [15:0] task_ids    [Levels][Depth];
   logic [1:0]  task_states [Levels][Depth];
   int          task_count  [Levels];

   mlps_pkg::req_type pending_reqs[$];
   bit                pending_drain[$];
   mlps_pkg::rsp_type sched_expect[$];
   int          accepted_reqs = 0;
   int          mismatches = 0;
   int          hold_cycles = 0;
   bit          hold_done = 0;
   bit          stim_done = 0;

   // Delete one entry and close the gap
   function automatic void drop_entry(int lv, int pos);
      for (int k = pos; k + 1 < task_count[lv]; k++) begin
         task_ids[lv][k]    = task_ids[lv][k + 1];
         task_states[lv][k] = task_states[lv][k + 1];
      end
      task_count[lv]--;
   endfunction

   function automatic bit purge_id(int lv, logic [15:0] id);
      int k;
      bit hit;
      k = 0;
      hit = 0;
      while (k < task_count[lv]) begin
         if (task_ids[lv][k] == id) begin
            drop_entry(lv, k);
            hit = 1;
         end else begin
            k++;
         end
      end
      return hit;
   endfunction

   function automatic mlps_pkg::rsp_type schedule_outcome(mlps_pkg::req_type r);
      mlps_pkg::rsp_type o;
      int      lv;
      int      first;
      int      k;
      bit      any;
      bit      missing;
      bit      found;
      logic [15:0] run_id;
      o = '0;
      o.status = mlps_pkg::STS_OK;
      lv = r.level;
      case (mlps_pkg::op_type'(r.op))
         mlps_pkg::OP_INSERT: begin
            if (lv >= Levels || task_count[lv] >= Depth) begin
               o.status = mlps_pkg::STS_FULL;
            end else begin
               task_ids[lv][task_count[lv]]    = r.task_id;
               task_states[lv][task_count[lv]] = r.state_value;
               task_count[lv]++;
            end
         end
         mlps_pkg::OP_REMOVE: begin
            if (lv >= Levels) o.status = mlps_pkg::STS_NOTFOUND;
            else if (!purge_id(lv, r.task_id)) o.status = mlps_pkg::STS_NOTFOUND;
         end
         mlps_pkg::OP_REM_RUN: begin
            any = 0;
            missing = 0;
            for (int i = 0; i < Levels; i++) begin
               if (task_count[i] != 0) begin
                  any = 1;
                  found = 0;
                  run_id = '0;
                  for (int j = 0; j < task_count[i]; j++)
                     if (task_states[i][j] == mlps_pkg::StRunning) begin
                        found = 1;
                        run_id = task_ids[i][j];
                     end
                  if (found) void'(purge_id(i, run_id));
                  else missing = 1;
               end
            end
            o.status = !any ? mlps_pkg::STS_EMPTY :
                       (missing ? mlps_pkg::STS_NOTFOUND : mlps_pkg::STS_OK);
         end
         mlps_pkg::OP_SCHED: begin
            first = Levels;
            for (int i = Levels - 1; i >= 0; i--)
               if (task_count[i] > 0) first = i;
            if (first == Levels) begin
               o.status = mlps_pkg::STS_EMPTY;
            end else begin
               o.result_level = 3'(first);
               k = 0;
               while (k < task_count[first] && task_states[first][k] != mlps_pkg::StReady)
                  k++;
               if (k == task_count[first]) begin
                  o.status = mlps_pkg::STS_NOREADY;
               end else begin
                  o.result_id = task_ids[first][k];
                  drop_entry(first, k);
                  task_ids[first][task_count[first]]    = o.result_id;
                  task_states[first][task_count[first]] = mlps_pkg::StRunning;
                  task_count[first]++;
               end
            end
         end
         mlps_pkg::OP_SET: begin
            found = 0;
            for (int i = 0; i < Levels; i++)
               for (int j = 0; j < task_count[i]; j++)
                  if (task_ids[i][j] == r.task_id &&
                      task_states[i][j] == mlps_pkg::StRunning) begin
                     task_states[i][j] = r.state_value;
                     found = 1;
                  end
            if (!found) o.status = mlps_pkg::STS_NOTFOUND;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic mlps_pkg::req_type mk_req(logic [2:0] op, logic [15:0] id,
                                                logic [2:0] lv, logic [1:0] sv);
      mlps_pkg::req_type r;
      r.op = op;
      r.task_id = id;
      r.level = lv;
      r.state_value = sv;
      return r;
   endfunction

   function automatic void queue_req(mlps_pkg::req_type r, bit drain);
      pending_reqs.push_back(r);
      pending_drain.push_back(drain);
   endfunction

   // Clock and reset
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   function automatic bit quiet_stretch();
      return accepted_reqs >= 350 && accepted_reqs < 450;
   endfunction

   // Driver: offer the next pending transfer at the falling edge
   bit req_taken = 0;
   initial begin
      req_valid = 0;
      req_data  = '0;
   end
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_reqs.size() != 0 &&
             !(pending_drain[0] && sched_expect.size() != 0) &&
             (quiet_stretch() || $urandom_range(99) >= 24)) begin
            req_data  <= pending_reqs.pop_front();
            void'(pending_drain.pop_front());
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
      req_taken = 0;
   end

   // Accept side: predict at each input transfer
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sched_expect.push_back(schedule_outcome(req_data));
         accepted_reqs++;
         req_taken = 1;
      end
   end

   // Receiver ready, with one long hold-off
   initial rsp_ready = 0;
   always @(negedge clock) begin
      if (!hold_done && accepted_reqs >= 150) begin
         hold_cycles++;
         if (hold_cycles >= 400) hold_done = 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= !reset && (quiet_stretch() || $urandom_range(99) >= 24);
      end
   end

   // Monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      mlps_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sched_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: %h", rsp_data);
         end else begin
            want = sched_expect.pop_front();
            if (rsp_data.result_id !== want.result_id ||
                rsp_data.result_level !== want.result_level ||
                rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected id %h level %0d status %0d,",
                            " got id %h level %0d status %0d"},
                           want.result_id, want.result_level, want.status,
                           rsp_data.result_id, rsp_data.result_level, rsp_data.status);
            end
         end
      end
   end

   // Stimulus
   initial begin
      mlps_pkg::req_type r;
      int      pick;
      // Corner cases, starting from an empty scheduler
      queue_req(mk_req(mlps_pkg::OP_SCHED, 16'h0, 3'd0, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_REM_RUN, 16'h0, 3'd0, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_SET, 16'h1234, 3'd0, 2'd2), 0);
      queue_req(mk_req(mlps_pkg::OP_REMOVE, 16'h1, 3'd6, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_INSERT, 16'h2, 3'd7, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_INSERT, 16'h0, 3'd0, 2'd3), 0);
      queue_req(mk_req(mlps_pkg::OP_INSERT, 16'hFFFF, 3'd0, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_INSERT, 16'hFFFF, 3'd5, 2'd1), 0);
      queue_req(mk_req(mlps_pkg::OP_SCHED, 16'h0, 3'd0, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_SET, 16'hFFFF, 3'd0, 2'd2), 0);
      queue_req(mk_req(mlps_pkg::OP_SCHED, 16'h0, 3'd0, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_REM_RUN, 16'h0, 3'd0, 2'd0), 0);
      queue_req(mk_req(3'd5, 16'hAAAA, 3'd1, 2'd1), 0);
      queue_req(mk_req(3'd7, 16'h5555, 3'd2, 2'd2), 0);
      queue_req(mk_req(mlps_pkg::OP_REMOVE, 16'h7, 3'd0, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_REMOVE, 16'h0, 3'd0, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_REMOVE, 16'hFFFF, 3'd0, 2'd0), 0);
      queue_req(mk_req(mlps_pkg::OP_REMOVE, 16'hFFFF, 3'd5, 2'd0), 0);
      // Fill one level past capacity
      for (int i = 0; i < 17; i++)
         queue_req(mk_req(mlps_pkg::OP_INSERT, i[15:0], 3'd3, 2'd0), 0);
      // Random traffic over a small id pool so ids collide
      for (int i = 0; i < 600; i++) begin
         pick = $urandom_range(99);
         r.op = pick < 40 ? mlps_pkg::OP_INSERT : pick < 55 ? mlps_pkg::OP_REMOVE :
                pick < 65 ? mlps_pkg::OP_REM_RUN : pick < 83 ? mlps_pkg::OP_SCHED :
                pick < 97 ? mlps_pkg::OP_SET : 3'($urandom_range(7, 5));
         r.task_id = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(7));
         r.level = $urandom_range(19) == 0 ? 3'($urandom_range(7, 6)) :
                   3'($urandom_range(5));
         r.state_value = $urandom_range(2) == 0 ? 2'($urandom_range(3)) :
                         2'($urandom_range(1));
         queue_req(r, i == 300);
      end
      stim_done = 1;
   end

   // End of run
   initial begin
      @(posedge clock);
      while (!stim_done || pending_reqs.size() != 0 || req_valid ||
             sched_expect.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && sched_expect.size() == 0)
         $display("multilevel_priority_scheduler_unit_tb OK");
      else
         $display("multilevel_priority_scheduler_unit_tb NOT OK");
      $finish;
   end

   initial begin
      #20ms;
      $display("multilevel_priority_scheduler_unit_tb NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
sv/mlps_pkg.sv
sv/multilevel_priority_scheduler_unit.sv
tb/sv/multilevel_priority_scheduler_unit_tb.sv
